FILE: hw/rtl/vpd_pkg.sv
`default_nettype none

package vpd_pkg;

  // Largest number of coding modes the mode map can describe.
  localparam int MAX_MODES_DEF = 63;

  // Configuration port geometry: 64-bit data, registers at 8-byte steps.
  localparam int CFG_DATA_W = 64;
  localparam int CFG_ADDR_W = 5;

  // Register indexes, taken from paddr[4:3].
  localparam logic [1:0] REG_SETUP_VALID     = 2'd0;
  localparam logic [1:0] REG_BLOCK_SIZE_BYTE = 2'd1;
  localparam logic [1:0] REG_MODE_COUNT      = 2'd2;
  localparam logic [1:0] REG_MODE_SIZE_MAP   = 2'd3;

  // Result status codes.
  localparam logic [2:0] STATUS_OK         = 3'd0;
  localparam logic [2:0] STATUS_ID_HEADER  = 3'd1;
  localparam logic [2:0] STATUS_COMMENT    = 3'd2;
  localparam logic [2:0] STATUS_BAD_PACKET = 3'd3;
  localparam logic [2:0] STATUS_BAD_MODE   = 3'd4;
  localparam logic [2:0] STATUS_NOT_READY  = 3'd5;

  // First bytes of the two header packets that can be reported.
  localparam logic [7:0] BYTE_ID_HEADER = 8'd1;
  localparam logic [7:0] BYTE_COMMENT   = 8'd3;

  typedef struct packed {
    logic       restart;
    logic [7:0] first_byte;
    logic       packet_empty;
    logic       want_flags;
  } vpd_item_t;

  typedef struct packed {
    logic       setup_valid;
    logic [7:0] block_size_byte;
    logic [5:0] num_modes;
  } vpd_cfg_t;

  typedef struct packed {
    logic [14:0] duration;
    logic [2:0]  status;
    logic        prev_we;
    logic        prev_val;
  } vpd_result_t;

  // Bits needed to code the values 0 .. n-1.
  function automatic logic [2:0] mode_bits(input logic [5:0] n);
    logic [5:0] v;
    logic [2:0] b;
    v = n - 6'd1;
    b = '0;
    for (int i = 0; i < 6; i++) begin
      if (v[i]) begin
        b = 3'(i + 1);
      end
    end
    return b;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/vpd_decode.sv
`default_nettype none

module vpd_decode
  import vpd_pkg::*;
#(
  parameter int MAX_MODES = MAX_MODES_DEF
) (
  input  vpd_item_t              item,
  input  vpd_cfg_t               cfg,
  input  logic [MAX_MODES-1:0]   mode_size_map,
  input  logic                   prev_long,
  output vpd_result_t            result
);

  localparam logic [5:0] MaxCount = 6'(MAX_MODES);

  logic [5:0]           count;
  logic [2:0]           nb;
  logic [6:0]           mask;
  logic [5:0]           sel;
  logic [2:0]           pb;
  logic [MAX_MODES-1:0] map_sh;
  logic                 cur_long;
  logic                 prev_sel;
  logic [3:0]           prev_sh;
  logic [3:0]           cur_sh;
  logic [16:0]          sum;

  always_comb begin
    count    = (cfg.num_modes > MaxCount) ? MaxCount : cfg.num_modes;
    nb       = mode_bits(count);
    mask     = 7'((8'd1 << nb) - 8'd1);
    // The mask never reaches bit 6, so dropping that bit in the six-bit select loses nothing.
    sel      = 6'(item.first_byte[7:1] & mask);
    pb       = (count == 6'd1) ? 3'd2 : nb + 3'd1;
    map_sh   = mode_size_map >> sel;
    cur_long = map_sh[0];
    prev_sel = cur_long ? item.first_byte[pb] : prev_long;
    prev_sh  = prev_sel ? cfg.block_size_byte[7:4] : cfg.block_size_byte[3:0];
    cur_sh   = cur_long ? cfg.block_size_byte[7:4] : cfg.block_size_byte[3:0];
    sum      = (17'd1 << prev_sh) + (17'd1 << cur_sh);

    result = '0;
    if (item.restart) begin
      result.status   = STATUS_OK;
      result.prev_we  = cfg.setup_valid;
      result.prev_val = 1'b0;
    end else if (!cfg.setup_valid || item.packet_empty) begin
      result.status = STATUS_NOT_READY;
    end else if (item.first_byte[0]) begin
      if (!item.want_flags) begin
        result.status = STATUS_BAD_PACKET;
      end else if (item.first_byte == BYTE_ID_HEADER) begin
        result.status = STATUS_ID_HEADER;
      end else if (item.first_byte == BYTE_COMMENT) begin
        result.status = STATUS_COMMENT;
      end else begin
        result.status = STATUS_BAD_PACKET;
      end
    end else if (count == 6'd0 || sel >= count) begin
      result.status = STATUS_BAD_MODE;
    end else begin
      result.status   = STATUS_OK;
      result.duration = sum[16:2];
      result.prev_we  = 1'b1;
      result.prev_val = cur_long;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vorbis_packet_duration.sv
// A packet beat is held in the input register, then its result in the result register.
// Throughput: one packet per cycle, limited only by the output stall.
// A packet waits in the input register only while the result register is full and stalled.
// Reset (rst, synchronous, active high) empties both registers, clears the previous-block
// flag and loads the configuration registers with their defaults.
`default_nettype none

module vorbis_packet_duration
  import vpd_pkg::*;
#(
  parameter int MAX_MODES = MAX_MODES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Packet channel.
  input  logic                  item_valid,
  output logic                  item_stall,
  input  logic                  mode,
  input  logic [7:0]            first_byte,
  input  logic                  packet_empty,
  input  logic                  want_flags,
  // Result channel.
  output logic                  result_valid,
  input  logic                  result_stall,
  output logic [14:0]           duration,
  output logic [2:0]            status,
  // Configuration port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // Configuration registers. The register index is paddr[4:3]; the low address bits
  // select nothing, so every register spans one 8-byte slot.
  logic                 setup_valid;
  logic [7:0]           block_size_byte;
  logic [5:0]           num_modes;
  logic [MAX_MODES-1:0] mode_size_map;

  // Remembers whether the last audio block was long; it sets the previous block size
  // for short modes.
  logic prev_long;

  // Input register and result register.
  logic        in_full;
  vpd_item_t   in_item;
  vpd_result_t res;

  logic cfg_we;
  logic load;
  logic move;
  logic out_free;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[4:3])
      REG_SETUP_VALID:     prdata = CFG_DATA_W'(setup_valid);
      REG_BLOCK_SIZE_BYTE: prdata = CFG_DATA_W'(block_size_byte);
      REG_MODE_COUNT:      prdata = CFG_DATA_W'(num_modes);
      REG_MODE_SIZE_MAP:   prdata = CFG_DATA_W'(mode_size_map);
      default:             prdata = '0;
    endcase
  end

  // The result register is free when it is empty or its beat is taken this cycle. A
  // packet in the input register moves on whenever it is free, so the input side stalls
  // only behind a stalled, full result register.
  assign out_free   = !result_valid || !result_stall;
  assign move       = in_full && out_free;
  assign item_stall = in_full && !out_free;
  assign load       = item_valid && !item_stall;

  vpd_decode #(
    .MAX_MODES(MAX_MODES)
  ) u_decode (
    .item          (in_item),
    .cfg           ('{setup_valid: setup_valid, block_size_byte: block_size_byte,
                      num_modes: num_modes}),
    .mode_size_map (mode_size_map),
    .prev_long     (prev_long),
    .result        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      setup_valid     <= 1'b0;
      block_size_byte <= 8'd184;
      num_modes       <= 6'd1;
      mode_size_map   <= '0;
    end else if (cfg_we) begin
      case (paddr[4:3])
        REG_SETUP_VALID:     setup_valid     <= pwdata[0];
        REG_BLOCK_SIZE_BYTE: block_size_byte <= pwdata[7:0];
        REG_MODE_COUNT:      num_modes       <= pwdata[5:0];
        REG_MODE_SIZE_MAP:   mode_size_map   <= pwdata[MAX_MODES-1:0];
        default:             ;
      endcase
    end
  end

  // Writing the mode map also loads the previous-block flag from map bit 0. Writes must
  // come only while the block is idle and meet no packet update; unchecked by the block.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_long <= 1'b0;
    end else if (cfg_we && paddr[4:3] == REG_MODE_SIZE_MAP) begin
      prev_long <= pwdata[0];
    end else if (move && res.prev_we) begin
      prev_long <= res.prev_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      in_full      <= load || (in_full && !move);
      result_valid <= move || (result_valid && result_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      in_item <= '{restart: mode, first_byte: first_byte, packet_empty: packet_empty,
                   want_flags: want_flags};
    end
    if (move) begin
      duration <= res.duration;
      status   <= res.status;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/vpd_checker.sv
`default_nettype none

module vpd_checker
  import vpd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              item_stall,
  input wire logic              result_valid,
  input wire logic              result_stall,
  input wire logic [14:0]       duration,
  input wire logic [2:0]        status
);

  // A stalled result beat holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(duration) && $stable(status))
    else $error("result beat changed while stalled");

  // Only audio beats carry samples.
  a_zero_duration: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != STATUS_OK |-> duration == 15'd0)
    else $error("non-audio result with nonzero duration");

  // The packet side stalls only behind a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("packet stalled while the result side was free");

  // Reset leaves no result beat behind.
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result beat present right after reset");

endmodule

bind vorbis_packet_duration vpd_checker u_vpd_checker (.*);

`default_nettype wire
